### rtl/core/rv64i_itype_execute_defines.svh
// ----------------------------------------------------------------------------
// rv64i_itype_execute_defines.svh
// Assertion macros shared by the I-type execute unit.
// ----------------------------------------------------------------------------
`ifndef RV64I_ITYPE_EXECUTE_DEFINES_SVH
`define RV64I_ITYPE_EXECUTE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define RVIE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define RVIE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rvie_pkg.sv
// ----------------------------------------------------------------------------
// rvie_pkg
// Types and constants of the RV64I I-type execute unit.
// ----------------------------------------------------------------------------
package rvie_pkg;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ILLEGAL = 3'd1,
        ST_ECALL   = 3'd2,
        ST_EBREAK  = 3'd3,
        ST_FENCE   = 3'd4
    } status_t;

    // Major opcodes
    localparam logic [6:0] OPC_OP_IMM    = 7'h13;
    localparam logic [6:0] OPC_OP_IMM_32 = 7'h1B;
    localparam logic [6:0] OPC_LOAD      = 7'h03;
    localparam logic [6:0] OPC_JALR      = 7'h67;
    localparam logic [6:0] OPC_SYSTEM    = 7'h73;
    localparam logic [6:0] OPC_MISC_MEM  = 7'h0F;

    // OP-IMM / OP-IMM-32 funct3
    localparam logic [2:0] F3_ADDI  = 3'd0;
    localparam logic [2:0] F3_SLLI  = 3'd1;
    localparam logic [2:0] F3_SLTI  = 3'd2;
    localparam logic [2:0] F3_SLTIU = 3'd3;
    localparam logic [2:0] F3_XORI  = 3'd4;
    localparam logic [2:0] F3_SRI   = 3'd5;
    localparam logic [2:0] F3_ORI   = 3'd6;
    localparam logic [2:0] F3_ANDI  = 3'd7;

    // Load funct3
    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LD   = 3'd3;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;
    localparam logic [2:0] F3_LWU  = 3'd6;
    localparam logic [2:0] F3_LRSV = 3'd7;

    localparam logic [2:0]  F3_ZERO     = 3'd0;
    localparam logic [11:0] IMM_ECALL   = 12'd0;
    localparam logic [11:0] IMM_EBREAK  = 12'd1;
    localparam logic [5:0]  SHIFT_ARITH = 6'b010000;
    localparam logic [5:0]  SHIFT_LOGIC = 6'b000000;
    localparam logic [63:0] TARGET_MASK = 64'hFFFF_FFFF_FFFF_FFFE;
    localparam logic [63:0] PC_STEP     = 64'd4;

    typedef struct packed {
        logic [6:0]         opcode;
        logic [2:0]         funct3;
        logic [4:0]         dest_index;
        logic [4:0]         src_index;
        logic [63:0]        src_value;
        logic signed [11:0] immediate;
        logic [63:0]        cur_pc;
        logic [63:0]        load_data;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic        reg_write;
        logic [4:0]  write_index;
        logic [63:0] write_value;
        logic        pc_write;
        logic [63:0] target_pc;
        logic        mem_read;
        logic [63:0] mem_addr;
        logic [1:0]  mem_size;
    } result_t;

endpackage

### rtl/core/rvie_alu.sv
// ----------------------------------------------------------------------------
// rvie_alu
// Decode and execute of one I-type instruction, purely combinational.
// ----------------------------------------------------------------------------
module rvie_alu
(
    input  rvie_pkg::item_t   item,
    output rvie_pkg::result_t result
);

    logic [63:0]        imm64;
    logic [63:0]        sum;
    logic [31:0]        sum32;
    logic [5:0]         hi6;
    logic [5:0]         sh64;
    logic [4:0]         sh32;
    logic signed [63:0] a_s;
    logic signed [31:0] aw_s;
    logic [31:0]        sll32;
    logic [31:0]        srl32;
    logic [31:0]        sra32;

    rvie_pkg::status_t  status;
    logic               wr;
    logic [63:0]        val;
    logic               pcw;
    logic [63:0]        tgt;
    logic               mrd;
    logic [63:0]        addr;
    logic [1:0]         size;

    assign imm64 = {{52{item.immediate[11]}}, item.immediate};
    assign sum   = item.src_value + imm64;
    assign sum32 = sum[31:0];
    assign hi6   = item.immediate[11:6];
    assign sh64  = item.immediate[5:0];
    assign sh32  = item.immediate[4:0];
    assign a_s   = item.src_value;
    assign aw_s  = item.src_value[31:0];
    assign sll32 = item.src_value[31:0] << sh32;
    assign srl32 = item.src_value[31:0] >> sh32;
    assign sra32 = aw_s >>> sh32;

    always_comb
    begin
        status = rvie_pkg::ST_OK;
        wr     = 1'b0;
        val    = '0;
        pcw    = 1'b0;
        tgt    = '0;
        mrd    = 1'b0;
        addr   = '0;
        size   = '0;

        unique case (item.opcode)
            rvie_pkg::OPC_OP_IMM:
            begin
                wr = 1'b1;
                unique case (item.funct3)
                    rvie_pkg::F3_ADDI:  val = sum;
                    rvie_pkg::F3_SLLI:
                    begin
                        if (hi6 == rvie_pkg::SHIFT_LOGIC)
                            val = item.src_value << sh64;
                        else
                            status = rvie_pkg::ST_ILLEGAL;
                    end
                    rvie_pkg::F3_SLTI:  val = {63'd0, a_s < $signed(imm64)};
                    rvie_pkg::F3_SLTIU: val = {63'd0, item.src_value < imm64};
                    rvie_pkg::F3_XORI:  val = item.src_value ^ imm64;
                    rvie_pkg::F3_SRI:
                    begin
                        if (hi6 == rvie_pkg::SHIFT_ARITH)
                            val = a_s >>> sh64;
                        else if (hi6 == rvie_pkg::SHIFT_LOGIC)
                            val = item.src_value >> sh64;
                        else
                            status = rvie_pkg::ST_ILLEGAL;
                    end
                    rvie_pkg::F3_ORI:   val = item.src_value | imm64;
                    default:            val = item.src_value & imm64;
                endcase
            end
            rvie_pkg::OPC_OP_IMM_32:
            begin
                wr = 1'b1;
                unique case (item.funct3)
                    rvie_pkg::F3_ADDI: val = {{32{sum32[31]}}, sum32};
                    rvie_pkg::F3_SLLI:
                    begin
                        if (hi6 == rvie_pkg::SHIFT_LOGIC)
                            val = {{32{sll32[31]}}, sll32};
                        else
                            status = rvie_pkg::ST_ILLEGAL;
                    end
                    rvie_pkg::F3_SRI:
                    begin
                        if (hi6 == rvie_pkg::SHIFT_ARITH)
                            val = {{32{sra32[31]}}, sra32};
                        else if (hi6 == rvie_pkg::SHIFT_LOGIC)
                            val = {{32{srl32[31]}}, srl32};
                        else
                            status = rvie_pkg::ST_ILLEGAL;
                    end
                    default: status = rvie_pkg::ST_ILLEGAL;
                endcase
            end
            rvie_pkg::OPC_LOAD:
            begin
                wr   = 1'b1;
                mrd  = 1'b1;
                addr = sum;
                size = item.funct3[1:0];
                unique case (item.funct3)
                    rvie_pkg::F3_LB:  val = {{56{item.load_data[7]}}, item.load_data[7:0]};
                    rvie_pkg::F3_LH:  val = {{48{item.load_data[15]}}, item.load_data[15:0]};
                    rvie_pkg::F3_LW:  val = {{32{item.load_data[31]}}, item.load_data[31:0]};
                    rvie_pkg::F3_LD:  val = item.load_data;
                    rvie_pkg::F3_LBU: val = {56'd0, item.load_data[7:0]};
                    rvie_pkg::F3_LHU: val = {48'd0, item.load_data[15:0]};
                    rvie_pkg::F3_LWU: val = {32'd0, item.load_data[31:0]};
                    default:          status = rvie_pkg::ST_ILLEGAL;
                endcase
            end
            rvie_pkg::OPC_JALR:
            begin
                if (item.funct3 != rvie_pkg::F3_ZERO)
                    status = rvie_pkg::ST_ILLEGAL;
                else
                begin
                    wr  = 1'b1;
                    val = item.cur_pc + rvie_pkg::PC_STEP;
                    pcw = 1'b1;
                    tgt = sum & rvie_pkg::TARGET_MASK;
                end
            end
            rvie_pkg::OPC_SYSTEM:
            begin
                if (item.src_index != 5'd0 || item.dest_index != 5'd0
                    || item.funct3 != rvie_pkg::F3_ZERO)
                    status = rvie_pkg::ST_ILLEGAL;
                else if (item.immediate == rvie_pkg::IMM_ECALL)
                    status = rvie_pkg::ST_ECALL;
                else if (item.immediate == rvie_pkg::IMM_EBREAK)
                    status = rvie_pkg::ST_EBREAK;
                else
                    status = rvie_pkg::ST_ILLEGAL;
            end
            rvie_pkg::OPC_MISC_MEM: status = rvie_pkg::ST_FENCE;
            default:                status = rvie_pkg::ST_ILLEGAL;
        endcase

        // any non-ok status drops every effect
        if (status != rvie_pkg::ST_OK)
        begin
            wr   = 1'b0;
            val  = '0;
            pcw  = 1'b0;
            tgt  = '0;
            mrd  = 1'b0;
            addr = '0;
            size = '0;
        end
    end

    always_comb
    begin
        result.status      = status;
        result.reg_write   = wr;
        result.write_index = wr ? item.dest_index : 5'd0;
        result.write_value = val;
        result.pc_write    = pcw;
        result.target_pc   = tgt;
        result.mem_read    = mrd;
        result.mem_addr    = addr;
        result.mem_size    = size;
    end

endmodule

### rtl/core/rv64i_itype_execute.sv
// ----------------------------------------------------------------------------
// rv64i_itype_execute
// Execute stage for RV64I I-type instructions (op-imm, op-imm-32, load,
// jalr, system, fence).
// ----------------------------------------------------------------------------
// Usage:
//   One instruction enters on the s_axis channel as a word: opcode and funct3
//   in tuser, operands in tdata. One result word leaves on m_axis for each
//   instruction: status in tuser, register write, pc redirect and memory
//   read request in tdata. Loads expect load_data already read at the load
//   address; the block only extends it.
//   Result valid rises when the executed word is loaded into the result
//   register; decode and execute run between the input register and the
//   result register. One instruction per cycle while the sink takes results.
//   Both registers advance whenever the result register is empty or being
//   taken, so s_axis_tready falls only while m_axis_tready is low and both
//   stages are full; held words stay put until taken.
//   Reset empties both stages; no word is shown until a new one is taken in.
// ----------------------------------------------------------------------------
`include "rv64i_itype_execute_defines.svh"

module rv64i_itype_execute
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // dest_index[4:0], src_index[9:5], src_value[73:10], immediate[85:74],
    // cur_pc[149:86], load_data[213:150], zero pad[215:214]
    input  logic [215:0] s_axis_tdata,
    // opcode[6:0], funct3[9:7]
    input  logic [9:0]   s_axis_tuser,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // reg_write[0], write_index[5:1], write_value[69:6], pc_write[70],
    // target_pc[134:71], mem_read[135], mem_addr[199:136], mem_size[201:200],
    // zero pad[207:202]
    output logic [207:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]   m_axis_tuser
);

    rvie_pkg::item_t   in_item;
    rvie_pkg::item_t   item_reg;
    rvie_pkg::result_t exec_result;
    rvie_pkg::result_t result_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              load_in;

    assign in_item.opcode     = s_axis_tuser[6:0];
    assign in_item.funct3     = s_axis_tuser[9:7];
    assign in_item.dest_index = s_axis_tdata[4:0];
    assign in_item.src_index  = s_axis_tdata[9:5];
    assign in_item.src_value  = s_axis_tdata[73:10];
    assign in_item.immediate  = s_axis_tdata[85:74];
    assign in_item.cur_pc     = s_axis_tdata[149:86];
    assign in_item.load_data  = s_axis_tdata[213:150];

    // result stage moves when it is empty or its word is being taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign load_in       = s_axis_tvalid && s_axis_tready;

    rvie_alu u_alu
    (
        .item   (item_reg),
        .result (exec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
            item_reg <= in_item;
        if (advance && in_valid_reg)
            result_reg <= exec_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = result_reg.status;
    assign m_axis_tdata  = {6'd0,
                            result_reg.mem_size,
                            result_reg.mem_addr,
                            result_reg.mem_read,
                            result_reg.target_pc,
                            result_reg.pc_write,
                            result_reg.write_value,
                            result_reg.write_index,
                            result_reg.reg_write};

    `RVIE_ASSERT_NEXT(a_stage_moves, in_valid_reg && advance, out_valid_reg,
        "executed word did not reach the result stage")
    `RVIE_ASSERT_SAME(a_fault_no_effects,
        out_valid_reg && result_reg.status != rvie_pkg::ST_OK, m_axis_tdata == '0,
        "non-ok status carries effects")
    `RVIE_ASSERT_SAME(a_single_effect_kind, out_valid_reg,
        !(result_reg.mem_read && result_reg.pc_write),
        "load and jump flagged together")
    `RVIE_ASSERT_SAME(a_no_write_no_value, out_valid_reg && !result_reg.reg_write,
        result_reg.write_value == '0 && result_reg.write_index == '0,
        "write value present without register write")

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: rv64i_itype_execute stream testbench
// Sends RV64I I-type instructions on s_axis and checks every result word on
// m_axis field by field against a predictor. A directed set covers the corner
// cases of each opcode. Random phases follow with source and sink idling at
// different rates, and one phase holds the sink off so that both stages fill.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 440;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [215:0] s_axis_tdata;
    logic [9:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [207:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    rvie_pkg::result_t expected_results[$];
    int      fail_count     = 0;
    int      cycle_count    = 0;
    int      source_idle_pct = 0;
    int      sink_stall_pct  = 0;
    int      sink_hold_left  = 0;

    rv64i_itype_execute DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** rv64i_itype_execute: FAILED **");
            $finish;
        end
    end

    // Sink: a long hold-off takes priority over random stalls.
    always @(negedge clk)
    begin
        if (sink_hold_left > 0)
        begin
            sink_hold_left = sink_hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic rvie_pkg::result_t predict_execute(input rvie_pkg::item_t it);
        rvie_pkg::result_t r;
        rvie_pkg::status_t st;
        logic [63:0] a;
        logic [63:0] imm;
        logic [63:0] sum;
        logic [5:0]  hi6;
        logic [5:0]  sh64;
        logic [4:0]  sh32;
        logic [31:0] word_val;

        r    = '0;
        st   = rvie_pkg::ST_OK;
        a    = it.src_value;
        imm  = {{52{it.immediate[11]}}, it.immediate};
        sum  = a + imm;
        hi6  = imm[11:6];
        sh64 = imm[5:0];
        sh32 = imm[4:0];

        case (it.opcode)
            rvie_pkg::OPC_OP_IMM:
            begin
                r.reg_write = 1'b1;
                case (it.funct3)
                    rvie_pkg::F3_ADDI:  r.write_value = sum;
                    rvie_pkg::F3_SLLI:
                        if (hi6 == rvie_pkg::SHIFT_LOGIC) r.write_value = a << sh64;
                        else st = rvie_pkg::ST_ILLEGAL;
                    rvie_pkg::F3_SLTI:  r.write_value = {63'd0, $signed(a) < $signed(imm)};
                    rvie_pkg::F3_SLTIU: r.write_value = {63'd0, a < imm};
                    rvie_pkg::F3_XORI:  r.write_value = a ^ imm;
                    rvie_pkg::F3_SRI:
                        if (hi6 == rvie_pkg::SHIFT_ARITH)
                            r.write_value = $signed(a) >>> sh64;
                        else if (hi6 == rvie_pkg::SHIFT_LOGIC)
                            r.write_value = a >> sh64;
                        else
                            st = rvie_pkg::ST_ILLEGAL;
                    rvie_pkg::F3_ORI:   r.write_value = a | imm;
                    default:            r.write_value = a & imm;
                endcase
            end
            rvie_pkg::OPC_OP_IMM_32:
            begin
                r.reg_write = 1'b1;
                word_val    = '0;
                case (it.funct3)
                    rvie_pkg::F3_ADDI: word_val = a[31:0] + imm[31:0];
                    rvie_pkg::F3_SLLI:
                        if (hi6 == rvie_pkg::SHIFT_LOGIC) word_val = a[31:0] << sh32;
                        else st = rvie_pkg::ST_ILLEGAL;
                    rvie_pkg::F3_SRI:
                        if (hi6 == rvie_pkg::SHIFT_ARITH)
                            word_val = $signed(a[31:0]) >>> sh32;
                        else if (hi6 == rvie_pkg::SHIFT_LOGIC)
                            word_val = a[31:0] >> sh32;
                        else
                            st = rvie_pkg::ST_ILLEGAL;
                    default: st = rvie_pkg::ST_ILLEGAL;
                endcase
                r.write_value = {{32{word_val[31]}}, word_val};
            end
            rvie_pkg::OPC_LOAD:
            begin
                if (it.funct3 == rvie_pkg::F3_LRSV)
                    st = rvie_pkg::ST_ILLEGAL;
                else
                begin
                    r.reg_write = 1'b1;
                    r.mem_read  = 1'b1;
                    r.mem_addr  = sum;
                    r.mem_size  = it.funct3[1:0];
                    case (it.funct3)
                        rvie_pkg::F3_LB:
                            r.write_value = {{56{it.load_data[7]}}, it.load_data[7:0]};
                        rvie_pkg::F3_LH:
                            r.write_value = {{48{it.load_data[15]}}, it.load_data[15:0]};
                        rvie_pkg::F3_LW:
                            r.write_value = {{32{it.load_data[31]}}, it.load_data[31:0]};
                        rvie_pkg::F3_LD:  r.write_value = it.load_data;
                        rvie_pkg::F3_LBU: r.write_value = {56'd0, it.load_data[7:0]};
                        rvie_pkg::F3_LHU: r.write_value = {48'd0, it.load_data[15:0]};
                        default:          r.write_value = {32'd0, it.load_data[31:0]};
                    endcase
                end
            end
            rvie_pkg::OPC_JALR:
            begin
                if (it.funct3 != rvie_pkg::F3_ZERO)
                    st = rvie_pkg::ST_ILLEGAL;
                else
                begin
                    r.reg_write   = 1'b1;
                    r.write_value = it.cur_pc + rvie_pkg::PC_STEP;
                    r.pc_write    = 1'b1;
                    r.target_pc   = sum & rvie_pkg::TARGET_MASK;
                end
            end
            rvie_pkg::OPC_SYSTEM:
            begin
                if (it.src_index != 5'd0 || it.dest_index != 5'd0
                    || it.funct3 != rvie_pkg::F3_ZERO)
                    st = rvie_pkg::ST_ILLEGAL;
                else if (it.immediate == rvie_pkg::IMM_ECALL)
                    st = rvie_pkg::ST_ECALL;
                else if (it.immediate == rvie_pkg::IMM_EBREAK)
                    st = rvie_pkg::ST_EBREAK;
                else
                    st = rvie_pkg::ST_ILLEGAL;
            end
            rvie_pkg::OPC_MISC_MEM: st = rvie_pkg::ST_FENCE;
            default:                st = rvie_pkg::ST_ILLEGAL;
        endcase

        if (st != rvie_pkg::ST_OK)
            r = '0;
        r.status      = st;
        r.write_index = r.reg_write ? it.dest_index : 5'd0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each result word taken by the sink with the oldest prediction.
    always @(posedge clk)
    begin
        rvie_pkg::result_t got;
        rvie_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status      = rvie_pkg::status_t'(m_axis_tuser);
            got.reg_write   = m_axis_tdata[0];
            got.write_index = m_axis_tdata[5:1];
            got.write_value = m_axis_tdata[69:6];
            got.pc_write    = m_axis_tdata[70];
            got.target_pc   = m_axis_tdata[134:71];
            got.mem_read    = m_axis_tdata[135];
            got.mem_addr    = m_axis_tdata[199:136];
            got.mem_size    = m_axis_tdata[201:200];
            if (expected_results.size() == 0)
            begin
                $error("result word arrived with no instruction outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", want.status, got.status);
                check_field("reg_write", want.reg_write, got.reg_write);
                check_field("write_index", want.write_index, got.write_index);
                check_field("write_value", want.write_value, got.write_value);
                check_field("pc_write", want.pc_write, got.pc_write);
                check_field("target_pc", want.target_pc, got.target_pc);
                check_field("mem_read", want.mem_read, got.mem_read);
                check_field("mem_addr", want.mem_addr, got.mem_addr);
                check_field("mem_size", want.mem_size, got.mem_size);
            end
        end
    end

    // Called and returns right after a falling edge.
    task automatic send_instr(input rvie_pkg::item_t it);
        while ($urandom_range(99) < source_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {it.funct3, it.opcode};
        s_axis_tdata  <= {2'b00, it.load_data, it.cur_pc, it.immediate, it.src_value,
                          it.src_index, it.dest_index};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_results.push_back(predict_execute(it));
        @(negedge clk);
    endtask

    function automatic rvie_pkg::item_t make_instr(input logic [6:0] opcode,
                                                   input logic [2:0] funct3,
                                                   input logic [4:0] rd,
                                                   input logic [4:0] rs1,
                                                   input logic [63:0] src,
                                                   input logic [11:0] imm,
                                                   input logic [63:0] pc,
                                                   input logic [63:0] ld);
        rvie_pkg::item_t it;
        it.opcode     = opcode;
        it.funct3     = funct3;
        it.dest_index = rd;
        it.src_index  = rs1;
        it.src_value  = src;
        it.immediate  = imm;
        it.cur_pc     = pc;
        it.load_data  = ld;
        return it;
    endfunction

    function automatic logic [63:0] rand_dword();
        case ($urandom_range(5))
            0:       return {$urandom_range(1) ? 32'hFFFF_FFFF : 32'd0, $urandom};
            1:       return {1'b1, 63'd0} ^ {32'd0, $urandom_range(3)};
            2:       return {32'd0, $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000}
                            + 64'($urandom_range(2)) - 64'd1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic rvie_pkg::item_t rand_instr();
        rvie_pkg::item_t it;
        logic [6:0]  legal_ops [6];
        legal_ops = '{rvie_pkg::OPC_OP_IMM, rvie_pkg::OPC_OP_IMM_32, rvie_pkg::OPC_LOAD,
                      rvie_pkg::OPC_JALR, rvie_pkg::OPC_SYSTEM, rvie_pkg::OPC_MISC_MEM};
        it.opcode     = ($urandom_range(99) < 88) ? legal_ops[$urandom_range(5)]
                                                  : 7'($urandom);
        it.funct3     = 3'($urandom);
        it.dest_index = 5'($urandom);
        it.src_index  = 5'($urandom);
        it.src_value  = rand_dword();
        it.immediate  = 12'($urandom);
        it.cur_pc     = rand_dword();
        it.load_data  = {$urandom, $urandom};
        // Steer most shifts to a legal encoding.
        if ((it.opcode == rvie_pkg::OPC_OP_IMM || it.opcode == rvie_pkg::OPC_OP_IMM_32)
            && (it.funct3 == rvie_pkg::F3_SLLI || it.funct3 == rvie_pkg::F3_SRI)
            && $urandom_range(99) < 80)
            it.immediate[11:6] = (it.funct3 == rvie_pkg::F3_SRI && $urandom_range(1))
                                 ? rvie_pkg::SHIFT_ARITH : rvie_pkg::SHIFT_LOGIC;
        // Mostly well-formed system words, so ecall and ebreak come up often.
        if (it.opcode == rvie_pkg::OPC_SYSTEM && $urandom_range(99) < 75)
        begin
            it.dest_index = 5'd0;
            it.src_index  = 5'd0;
            it.funct3     = rvie_pkg::F3_ZERO;
            it.immediate  = $urandom_range(1) ? rvie_pkg::IMM_EBREAK : rvie_pkg::IMM_ECALL;
        end
        if (it.opcode == rvie_pkg::OPC_JALR && $urandom_range(99) < 80)
            it.funct3 = rvie_pkg::F3_ZERO;
        return it;
    endfunction

    task automatic test_directed();
        logic [63:0] neg = 64'hFFFF_FFFF_FFFF_FFFF;
        logic [63:0] big = 64'h8000_0000_0000_0000;
        logic [63:0] ld  = 64'h8182_8384_8586_8788;
        source_idle_pct = 0;
        sink_stall_pct  = 0;
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM, rvie_pkg::F3_ADDI, 5'd31, 5'd31, neg,
                              12'h7FF, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM, rvie_pkg::F3_ADDI, 5'd0, 5'd1, big,
                              12'h800, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM, rvie_pkg::F3_SLLI, 5'd3, 5'd2, neg,
                              12'h03F, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM, rvie_pkg::F3_SLLI, 5'd3, 5'd2, neg,
                              12'h040, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM, rvie_pkg::F3_SLTI, 5'd4, 5'd2, neg,
                              12'h000, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM, rvie_pkg::F3_SLTIU, 5'd5, 5'd2, 64'd5,
                              12'hFFF, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM, rvie_pkg::F3_XORI, 5'd6, 5'd2, big,
                              12'hFFF, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM, rvie_pkg::F3_SRI, 5'd7, 5'd2, big,
                              12'h43F, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM, rvie_pkg::F3_SRI, 5'd7, 5'd2, big,
                              12'h03F, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM, rvie_pkg::F3_SRI, 5'd7, 5'd2, big,
                              12'hC01, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM, rvie_pkg::F3_ORI, 5'd8, 5'd2, 64'd0,
                              12'h800, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM, rvie_pkg::F3_ANDI, 5'd9, 5'd2, neg,
                              12'h800, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM_32, rvie_pkg::F3_ADDI, 5'd10, 5'd2,
                              64'h7FFF_FFFF, 12'h001, 0, 0));
        // Word shift with immediate bit 5 set: bit 5 is dropped.
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM_32, rvie_pkg::F3_SLLI, 5'd11, 5'd2,
                              64'h1, 12'h03F, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM_32, rvie_pkg::F3_SRI, 5'd12, 5'd2,
                              64'h8000_0000, 12'h41F, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_OP_IMM_32, rvie_pkg::F3_SLTI, 5'd13, 5'd2,
                              64'd1, 12'h001, 0, 0));
        for (int f = 0; f < 8; f++)
            send_instr(make_instr(rvie_pkg::OPC_LOAD, 3'(f), 5'(14 + f), 5'd2, neg,
                                  12'h800, 0, ld));
        send_instr(make_instr(rvie_pkg::OPC_JALR, rvie_pkg::F3_ZERO, 5'd1, 5'd2, 64'd7,
                              12'h000, neg - 3, 0));
        send_instr(make_instr(rvie_pkg::OPC_JALR, rvie_pkg::F3_SLLI, 5'd1, 5'd2, 64'd7,
                              12'h000, 64'd0, 0));
        send_instr(make_instr(rvie_pkg::OPC_SYSTEM, rvie_pkg::F3_ZERO, 5'd0, 5'd0, neg,
                              rvie_pkg::IMM_ECALL, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_SYSTEM, rvie_pkg::F3_ZERO, 5'd0, 5'd0, neg,
                              rvie_pkg::IMM_EBREAK, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_SYSTEM, rvie_pkg::F3_ZERO, 5'd0, 5'd1, 0,
                              rvie_pkg::IMM_ECALL, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_SYSTEM, rvie_pkg::F3_ZERO, 5'd0, 5'd0, 0,
                              12'h002, 0, 0));
        send_instr(make_instr(rvie_pkg::OPC_MISC_MEM, 3'd7, 5'd3, 5'd4, neg, 12'hFFF,
                              0, 0));
        send_instr(make_instr(7'h7F, rvie_pkg::F3_ADDI, 5'd3, 5'd4, neg, 12'h001, 0, 0));
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct);
        source_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        repeat (RANDOM_ITEMS)
            send_instr(rand_instr());
    endtask

    // Hold the sink off while the source keeps offering words; both stages fill.
    task automatic test_backpressure();
        source_idle_pct = 0;
        sink_stall_pct  = 0;
        sink_hold_left  = 60;
        repeat (30)
            send_instr(rand_instr());
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(0, 0);
        test_random(46, 0);
        test_random(0, 46);
        test_random(13, 13);
        test_backpressure();
        s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("** rv64i_itype_execute: PASSED **");
        else
            $display("** rv64i_itype_execute: FAILED **");
        $finish;
    end

endmodule
